// ===== sv/assert_macros.svh =====
// Assertion macros shared by the vegetation cell update RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define VCDU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vcdu assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define VCDU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vcdu assertion failed");

`endif

// ===== sv/vcdu_pkg.sv =====
// Types, codes and fixed-point constants of the vegetation cell update block.
package vcdu_pkg;

  localparam int CELLS_PER_AXIS       = 16;
  localparam int RECOVERY_TABLE_DEPTH = 256;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic        [16:0] UNIT_ONE      = 17'd65536;
  localparam logic        [31:0] DECAY_Q32     = 32'd4289087807;
  localparam logic        [33:0] BIOMASS_TOL   = 34'd8590;
  localparam logic        [16:0] MOIST_FLOOR   = 17'd6554;
  localparam logic        [15:0] MOIST_SPAN    = 16'd39322;
  localparam logic        [16:0] MOIST_RECIP   = 17'd109225;
  localparam logic signed [16:0] TEMP_OFFSET   = 17'sd512;
  localparam logic signed [16:0] TEMP_SPAN     = 17'sd4608;
  localparam logic        [20:0] TEMP_RECIP    = 21'd1864136;
  localparam logic        [12:0] MAX_CELL_SIZE = 13'd4096;

  typedef logic [23:0] rec_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_LOCAL_SIZE,
    CFG_REGION_SIZE,
    CFG_SEA_LEVEL
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CELL_LAND,
    CELL_WATER,
    CELL_OUTSIDE,
    CELL_INVALID
  } cell_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_MUL5,
    ST_LOOKUP,
    ST_STEP,
    ST_BIO,
    ST_WEIGHT,
    ST_ACC,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL1,
    OP_MUL2,
    OP_MUL3,
    OP_MUL4,
    OP_MUL5,
    OP_LOOKUP,
    OP_STEP,
    OP_BIO,
    OP_WEIGHT,
    OP_ACC,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== sv/vcdu_ctrl.sv =====
// Sequencing controller: steps the datapath through one cell per transfer.
`include "assert_macros.svh"

module vcdu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  vcdu_pkg::sts_t  sts_i,
  output vcdu_pkg::cmd_t  cmd_o
);

  vcdu_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vcdu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = vcdu_pkg::OP_NONE;
    in_stall_o = 1'b1;
    case (state_q)
      vcdu_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = vcdu_pkg::OP_LOAD;
          state_d  = vcdu_pkg::ST_MUL1;
        end
      end
      vcdu_pkg::ST_MUL1: begin
        cmd_o.op = vcdu_pkg::OP_MUL1;
        state_d  = vcdu_pkg::ST_MUL2;
      end
      vcdu_pkg::ST_MUL2: begin
        cmd_o.op = vcdu_pkg::OP_MUL2;
        state_d  = vcdu_pkg::ST_MUL3;
      end
      vcdu_pkg::ST_MUL3: begin
        cmd_o.op = vcdu_pkg::OP_MUL3;
        state_d  = vcdu_pkg::ST_MUL4;
      end
      vcdu_pkg::ST_MUL4: begin
        cmd_o.op = vcdu_pkg::OP_MUL4;
        state_d  = vcdu_pkg::ST_MUL5;
      end
      vcdu_pkg::ST_MUL5: begin
        cmd_o.op = vcdu_pkg::OP_MUL5;
        state_d  = vcdu_pkg::ST_LOOKUP;
      end
      vcdu_pkg::ST_LOOKUP: begin
        cmd_o.op = vcdu_pkg::OP_LOOKUP;
        state_d  = vcdu_pkg::ST_STEP;
      end
      vcdu_pkg::ST_STEP: begin
        cmd_o.op = vcdu_pkg::OP_STEP;
        state_d  = vcdu_pkg::ST_BIO;
      end
      vcdu_pkg::ST_BIO: begin
        cmd_o.op = vcdu_pkg::OP_BIO;
        state_d  = vcdu_pkg::ST_WEIGHT;
      end
      vcdu_pkg::ST_WEIGHT: begin
        cmd_o.op = vcdu_pkg::OP_WEIGHT;
        state_d  = vcdu_pkg::ST_ACC;
      end
      vcdu_pkg::ST_ACC: begin
        cmd_o.op = vcdu_pkg::OP_ACC;
        state_d  = vcdu_pkg::ST_EMIT;
      end
      vcdu_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.op = vcdu_pkg::OP_EMIT;
          state_d  = vcdu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vcdu_pkg::ST_IDLE;
      end
    endcase
  end

  `VCDU_ASSERT_IMP(a_emit_needs_slot, cmd_o.op == vcdu_pkg::OP_EMIT, sts_i.out_free)
  `VCDU_ASSERT_NXT(a_load_starts_work, cmd_o.op == vcdu_pkg::OP_LOAD, state_q == vcdu_pkg::ST_MUL1)
  `VCDU_ASSERT_IMP(a_accept_is_load, in_valid_i && !in_stall_o, cmd_o.op == vcdu_pkg::OP_LOAD)

endmodule

// ===== sv/vcdu_dpath.sv =====
// Datapath: configuration, geometry, growth arithmetic, day totals and result register.
`include "assert_macros.svh"

module vcdu_dpath #(
  parameter int CellsPerAxis       = vcdu_pkg::CELLS_PER_AXIS,
  parameter int RecoveryTableDepth = vcdu_pkg::RECOVERY_TABLE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vcdu_pkg::cmd_t                 cmd_i,
  output vcdu_pkg::sts_t                 sts_o,
  input  logic                           cfg_we_i,
  input  logic [vcdu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vcdu_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic signed [15:0]             region_x_i,
  input  logic signed [15:0]             region_y_i,
  input  logic [7:0]                     local_index_i,
  input  logic signed [15:0]             mean_temperature_i,
  input  logic [16:0]                    soil_saturation_i,
  input  logic signed [17:0]             elevation_i,
  input  logic [16:0]                    forest_potential_i,
  input  logic [16:0]                    disturbance_before_i,
  input  logic [16:0]                    biomass_before_i,
  input  logic                           last_of_day_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     cell_status_o,
  output logic [16:0]                    disturbance_after_o,
  output logic [16:0]                    biomass_after_o,
  output logic [24:0]                    cell_area_o,
  output logic [31:0]                    land_count_total_o,
  output logic [47:0]                    land_area_total_o,
  output logic [47:0]                    biomass_area_before_o,
  output logic [47:0]                    biomass_area_after_o,
  output logic [47:0]                    disturbance_area_before_o,
  output logic [47:0]                    disturbance_area_after_o,
  output logic                           day_done_o,
  output logic                           day_error_o
);

  localparam int RowW = (CellsPerAxis > 1) ? $clog2(CellsPerAxis) : 1;
  localparam int IdxW = $clog2(RecoveryTableDepth);

  // configuration
  logic signed [23:0] box_q, boy_q;
  logic [23:0]        bw_q, bh_q;
  logic [12:0]        lcs_q;
  logic [16:0]        rcs_q;
  logic signed [17:0] sea_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
      boy_q <= '0;
      bw_q  <= '0;
      bh_q  <= '0;
      lcs_q <= 13'd1;
      rcs_q <= 17'd16;
      sea_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vcdu_pkg::CFG_ORIGIN_X:    box_q <= cfg_data_i;
        vcdu_pkg::CFG_ORIGIN_Y:    boy_q <= cfg_data_i;
        vcdu_pkg::CFG_WIDTH:       bw_q  <= cfg_data_i;
        vcdu_pkg::CFG_HEIGHT:      bh_q  <= cfg_data_i;
        vcdu_pkg::CFG_LOCAL_SIZE:  lcs_q <= cfg_data_i[12:0];
        vcdu_pkg::CFG_REGION_SIZE: rcs_q <= cfg_data_i[16:0];
        vcdu_pkg::CFG_SEA_LEVEL:   sea_q <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  // recovery table
  vcdu_pkg::rec_t rec_tab [RecoveryTableDepth];

  for (genvar g = 0; g < RecoveryTableDepth; g++) begin : g_rec
    localparam longint X  = (longint'(g) << 32) / longint'(RecoveryTableDepth - 1);
    localparam longint T  = X / 365;
    localparam longint SQ = T * T;
    localparam longint E  = T - (SQ >>> 33) + (((SQ >>> 32) * T) >>> 32) / 6;
    assign rec_tab[g] = vcdu_pkg::rec_t'(E);
  end

  // captured item
  logic signed [15:0] rx_q, ry_q, temp_q;
  logic [7:0]         idx_q;
  logic [16:0]        sat_q, pot_q, dist_q, bio_q;
  logic signed [17:0] elev_q;
  logic               last_q;

  // working registers
  logic signed [33:0] px_q, py_q, px_d, py_d;
  logic [16:0]        cx_q, cy_q, cx_d, cy_d;
  logic [33:0]        vp_q, vp_d;
  logic               range_ok_q, range_ok_d;
  logic               tlo_q, thi_q, tlo_d, thi_d;
  logic [40:0]        tv_q, tv_d;
  logic               mlo_q, mhi_q, mlo_d, mhi_d;
  logic [32:0]        mq_q, mq_d;
  logic [15:0]        u_q, u_d;
  logic [48:0]        dprod_q, dprod_d;
  logic signed [35:0] x0_q, y0_q, x0_d, y0_d;
  logic               valid_q, valid_d;
  logic [16:0]        tf_q, tf_d;
  logic [16:0]        qs_q, qs_d;
  logic [32:0]        mr_q, mr_d;
  logic [16:0]        dout_q, dout_d;
  logic signed [35:0] dx_q, dy_q, dx_d, dy_d;
  logic [16:0]        mf_q, mf_d;
  logic [33:0]        tp_q, tp_d;
  logic [24:0]        area_q, area_d;
  logic [16:0]        suit_q, suit_d;
  logic [16:0]        target_q, target_d;
  logic [1:0]         status_q, status_d;
  logic [IdxW-1:0]    ridx_q, ridx_d;
  logic [16:0]        diff_q, diff_d;
  logic               up_q, up_d;
  logic [41:0]        bpa_q, dpa_q, dopa_q, bpa_d, dpa_d, dopa_d;
  vcdu_pkg::rec_t     rec_q;
  logic [40:0]        sp_q, sp_d;
  logic [16:0]        bnew_q, bnew_d;
  logic [41:0]        bapa_q, bapa_d;

  // day totals
  logic [31:0] cnt_q, cnt_d;
  logic [47:0] larea_q, bbef_q, baft_q, dbef_q, daft_q;
  logic [47:0] larea_d, bbef_d, baft_d, dbef_d, daft_d;
  logic        err_q, err_d;

  // result register
  logic        out_valid_q;
  logic [1:0]  o_status_q;
  logic [16:0] o_dist_q, o_bio_q;
  logic [24:0] o_area_q;
  logic [31:0] o_cnt_q;
  logic [47:0] o_larea_q, o_bbef_q, o_baft_q, o_dbef_q, o_daft_q;
  logic        o_done_q, o_err_q;
  logic        o_skip;

  // combinational helpers
  logic [12:0]        s_size;
  logic [RowW-1:0]    row, col;
  logic [8:0]         col_full;
  logic signed [16:0] tn;
  logic [19:0]        tv_in;
  logic [16:0]        u_full;
  logic [49:0]        dround;
  logic signed [35:0] x1, y1, bx1, by1, ox0, oy0, ox1, oy1, bx0, by0;
  logic [32:0]        mrem;
  logic [16:0]        mcorr;
  logic               overlap;
  logic [29:0]        ridx_sum;
  logic [41:0]        sround;
  logic [9:0]         step;
  logic [17:0]        bcand;
  logic [48:0]        s_larea, s_bbef, s_baft, s_dbef, s_daft;
  logic               sat_any, land;

  assign s_size = (lcs_q > vcdu_pkg::MAX_CELL_SIZE) ? vcdu_pkg::MAX_CELL_SIZE : lcs_q;

  always_comb begin
    row = '0;
    for (int r = 1; r < CellsPerAxis; r++) begin
      if ({1'b0, idx_q} >= 9'(r * CellsPerAxis)) begin
        row = RowW'(r);
      end
    end
    col_full = {1'b0, idx_q} - 9'(row * CellsPerAxis);
    col      = col_full[RowW-1:0];
  end

  // step 1
  always_comb begin
    px_d = $signed(rx_q) * $signed({1'b0, rcs_q});
    py_d = $signed(ry_q) * $signed({1'b0, rcs_q});
    cx_d = 17'(col) * 17'(s_size);
    cy_d = 17'(row) * 17'(s_size);
    vp_d = 34'(pot_q) * 34'(17'(vcdu_pkg::UNIT_ONE - dist_q));
    range_ok_d = (pot_q <= vcdu_pkg::UNIT_ONE) && (dist_q <= vcdu_pkg::UNIT_ONE) &&
                 (bio_q <= vcdu_pkg::UNIT_ONE) && (sat_q <= vcdu_pkg::UNIT_ONE) &&
                 ({1'b0, idx_q} < 9'(CellsPerAxis * CellsPerAxis));
    tn    = $signed({temp_q[15], temp_q}) + vcdu_pkg::TEMP_OFFSET;
    tlo_d = (tn <= 17'sd0);
    thi_d = (tn >= vcdu_pkg::TEMP_SPAN);
    tv_in = {tn[12:0], 7'b0};
    tv_d  = 41'(tv_in) * 41'(vcdu_pkg::TEMP_RECIP);
    mlo_d  = (sat_q <= vcdu_pkg::MOIST_FLOOR);
    u_full = sat_q - vcdu_pkg::MOIST_FLOOR;
    mhi_d  = (u_full >= {1'b0, vcdu_pkg::MOIST_SPAN});
    u_d    = u_full[15:0];
    mq_d   = 33'(u_full[15:0]) * 33'(vcdu_pkg::MOIST_RECIP);
    dprod_d = 49'(dist_q) * 49'(vcdu_pkg::DECAY_Q32);
  end

  // step 2
  always_comb begin
    x0_d    = 36'(px_q) + $signed(36'(cx_q));
    y0_d    = 36'(py_q) + $signed(36'(cy_q));
    valid_d = range_ok_q && ({1'b0, bio_q, 16'b0} <= vp_q + vcdu_pkg::BIOMASS_TOL);
    tf_d    = tlo_q ? 17'd0 : (thi_q ? vcdu_pkg::UNIT_ONE : tv_q[40:24]);
    qs_d    = mq_q[32:16];
    mr_d    = 33'(mq_q[32:16]) * 33'(vcdu_pkg::MOIST_SPAN);
    dround  = 50'(dprod_q) + (50'd1 << 31);
    dout_d  = dround[48:32];
  end

  // step 3
  always_comb begin
    bx0  = 36'(box_q);
    by0  = 36'(boy_q);
    bx1  = bx0 + $signed(36'(bw_q));
    by1  = by0 + $signed(36'(bh_q));
    x1   = x0_q + $signed(36'(s_size));
    y1   = y0_q + $signed(36'(s_size));
    ox0  = (x0_q > bx0) ? x0_q : bx0;
    oy0  = (y0_q > by0) ? y0_q : by0;
    ox1  = (x1 < bx1) ? x1 : bx1;
    oy1  = (y1 < by1) ? y1 : by1;
    dx_d = ox1 - ox0;
    dy_d = oy1 - oy0;
    mrem  = {1'b0, u_q, 16'b0} - mr_q;
    mcorr = (mrem >= 33'(vcdu_pkg::MOIST_SPAN)) ? qs_q + 17'd1 : qs_q;
    mf_d  = mlo_q ? 17'd0 : (mhi_q ? vcdu_pkg::UNIT_ONE : mcorr);
    tp_d  = 34'(pot_q) * 34'(17'(vcdu_pkg::UNIT_ONE - dout_q));
  end

  // step 4
  always_comb begin
    logic [33:0] sp34;
    logic [33:0] tr34;
    overlap  = (dx_q > 36'sd0) && (dy_q > 36'sd0);
    area_d   = overlap ? 25'(26'(dx_q[12:0]) * 26'(dy_q[12:0])) : 25'd0;
    sp34     = 34'(tf_q) * 34'(mf_q);
    suit_d   = sp34[32:16];
    tr34     = tp_q + 34'd32768;
    target_d = tr34[32:16];
    land     = (elev_q > sea_q);
    if (!valid_q) begin
      status_d = vcdu_pkg::CELL_INVALID;
    end else if (!overlap) begin
      status_d = vcdu_pkg::CELL_OUTSIDE;
    end else if (!land) begin
      status_d = vcdu_pkg::CELL_WATER;
    end else begin
      status_d = vcdu_pkg::CELL_LAND;
    end
  end

  // step 5 to weight
  always_comb begin
    ridx_sum = 30'(suit_q) * 30'(RecoveryTableDepth - 1) + 30'd32768;
    ridx_d   = ridx_sum[IdxW+15:16];
    up_d     = (target_q >= bio_q);
    diff_d   = up_d ? target_q - bio_q : bio_q - target_q;
    bpa_d    = 42'(bio_q) * 42'(area_q);
    dpa_d    = 42'(dist_q) * 42'(area_q);
    dopa_d   = 42'(dout_q) * 42'(area_q);
    sp_d     = 41'(diff_q) * 41'(rec_q);
    sround   = 42'(sp_q) + (42'd1 << 31);
    step     = sround[41:32];
    if (up_q) begin
      bcand = 18'(bio_q) + 18'(step);
    end else if (17'(step) > bio_q) begin
      bcand = 18'd0;
    end else begin
      bcand = 18'(bio_q - 17'(step));
    end
    bnew_d = (bcand > 18'(target_q)) ? target_q : bcand[16:0];
    bapa_d = 42'(bnew_q) * 42'(area_q);
  end

  // totals
  always_comb begin
    s_larea = 49'(larea_q) + 49'(area_q);
    s_bbef  = 49'(bbef_q) + 49'(bpa_q);
    s_baft  = 49'(baft_q) + 49'(bapa_q);
    s_dbef  = 49'(dbef_q) + 49'(dpa_q);
    s_daft  = 49'(daft_q) + 49'(dopa_q);
    larea_d = s_larea[48] ? '1 : s_larea[47:0];
    bbef_d  = s_bbef[48] ? '1 : s_bbef[47:0];
    baft_d  = s_baft[48] ? '1 : s_baft[47:0];
    dbef_d  = s_dbef[48] ? '1 : s_dbef[47:0];
    daft_d  = s_daft[48] ? '1 : s_daft[47:0];
    cnt_d   = (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;
    sat_any = (cnt_q == '1) || s_larea[48] || s_bbef[48] || s_baft[48] ||
              s_dbef[48] || s_daft[48];
    err_d   = err_q;
    if (status_q == vcdu_pkg::CELL_INVALID) begin
      err_d = 1'b1;
    end else if (status_q == vcdu_pkg::CELL_LAND && sat_any) begin
      err_d = 1'b1;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      vcdu_pkg::OP_LOAD: begin
        rx_q   <= region_x_i;
        ry_q   <= region_y_i;
        idx_q  <= local_index_i;
        temp_q <= mean_temperature_i;
        sat_q  <= soil_saturation_i;
        elev_q <= elevation_i;
        pot_q  <= forest_potential_i;
        dist_q <= disturbance_before_i;
        bio_q  <= biomass_before_i;
        last_q <= last_of_day_i;
      end
      vcdu_pkg::OP_MUL1: begin
        px_q       <= px_d;
        py_q       <= py_d;
        cx_q       <= cx_d;
        cy_q       <= cy_d;
        vp_q       <= vp_d;
        range_ok_q <= range_ok_d;
        tlo_q      <= tlo_d;
        thi_q      <= thi_d;
        tv_q       <= tv_d;
        mlo_q      <= mlo_d;
        mhi_q      <= mhi_d;
        mq_q       <= mq_d;
        u_q        <= u_d;
        dprod_q    <= dprod_d;
      end
      vcdu_pkg::OP_MUL2: begin
        x0_q    <= x0_d;
        y0_q    <= y0_d;
        valid_q <= valid_d;
        tf_q    <= tf_d;
        qs_q    <= qs_d;
        mr_q    <= mr_d;
        dout_q  <= dout_d;
      end
      vcdu_pkg::OP_MUL3: begin
        dx_q <= dx_d;
        dy_q <= dy_d;
        mf_q <= mf_d;
        tp_q <= tp_d;
      end
      vcdu_pkg::OP_MUL4: begin
        area_q   <= area_d;
        suit_q   <= suit_d;
        target_q <= target_d;
        status_q <= status_d;
      end
      vcdu_pkg::OP_MUL5: begin
        ridx_q <= ridx_d;
        diff_q <= diff_d;
        up_q   <= up_d;
        bpa_q  <= bpa_d;
        dpa_q  <= dpa_d;
        dopa_q <= dopa_d;
      end
      vcdu_pkg::OP_LOOKUP: rec_q  <= rec_tab[ridx_q];
      vcdu_pkg::OP_STEP:   sp_q   <= sp_d;
      vcdu_pkg::OP_BIO:    bnew_q <= bnew_d;
      vcdu_pkg::OP_WEIGHT: bapa_q <= bapa_d;
      vcdu_pkg::OP_EMIT: begin
        o_status_q <= status_q;
        o_dist_q   <= (status_q == vcdu_pkg::CELL_LAND) ? dout_q : dist_q;
        case (status_q)
          vcdu_pkg::CELL_LAND:  o_bio_q <= bnew_q;
          vcdu_pkg::CELL_WATER: o_bio_q <= '0;
          default:              o_bio_q <= bio_q;
        endcase
        o_area_q  <= (status_q == vcdu_pkg::CELL_LAND || status_q == vcdu_pkg::CELL_WATER) ?
                     area_q : '0;
        o_cnt_q   <= last_q ? cnt_q : '0;
        o_larea_q <= last_q ? larea_q : '0;
        o_bbef_q  <= last_q ? bbef_q : '0;
        o_baft_q  <= last_q ? baft_q : '0;
        o_dbef_q  <= last_q ? dbef_q : '0;
        o_daft_q  <= last_q ? daft_q : '0;
        o_done_q  <= last_q;
        o_err_q   <= last_q && err_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      larea_q     <= '0;
      bbef_q      <= '0;
      baft_q      <= '0;
      dbef_q      <= '0;
      daft_q      <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == vcdu_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        vcdu_pkg::OP_ACC: begin
          err_q <= err_d;
          if (status_q == vcdu_pkg::CELL_LAND) begin
            cnt_q   <= cnt_d;
            larea_q <= larea_d;
            bbef_q  <= bbef_d;
            baft_q  <= baft_d;
            dbef_q  <= dbef_d;
            daft_q  <= daft_d;
          end
        end
        vcdu_pkg::OP_EMIT: begin
          if (last_q) begin
            cnt_q   <= '0;
            larea_q <= '0;
            bbef_q  <= '0;
            baft_q  <= '0;
            dbef_q  <= '0;
            daft_q  <= '0;
            err_q   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign o_skip = (o_status_q == vcdu_pkg::CELL_OUTSIDE) ||
                  (o_status_q == vcdu_pkg::CELL_INVALID);

  assign out_valid_o               = out_valid_q;
  assign cell_status_o             = o_status_q;
  assign disturbance_after_o       = o_dist_q;
  assign biomass_after_o           = o_bio_q;
  assign cell_area_o               = o_area_q;
  assign land_count_total_o        = o_cnt_q;
  assign land_area_total_o         = o_larea_q;
  assign biomass_area_before_o     = o_bbef_q;
  assign biomass_area_after_o      = o_baft_q;
  assign disturbance_area_before_o = o_dbef_q;
  assign disturbance_area_after_o  = o_daft_q;
  assign day_done_o                = o_done_q;
  assign day_error_o               = o_err_q;

  `VCDU_ASSERT_IMP(a_totals_only_on_done, out_valid_q && !o_done_q, o_cnt_q == '0 && !o_err_q)
  `VCDU_ASSERT_IMP(a_no_area_unapplied, out_valid_q && o_skip, o_area_q == '0)
  `VCDU_ASSERT_NXT(a_clear_after_day, cmd_i.op == vcdu_pkg::OP_EMIT && last_q, cnt_q == '0 && !err_q)

endmodule

// ===== sv/vegetation_cell_daily_update_top.sv =====
// Vegetation cell daily update: one local cell per input transfer, one result per cell.
// An accepted cell runs through eleven controller steps (geometry, decay, suitability,
// table lookup, biomass step, area weighting, day totals, result load); the next cell is
// taken only after the previous one has loaded its result, as the steps form a dependent
// multiply chain through the datapath. The result register frees the input side: the
// next cell is accepted while a result still waits, and only the final load waits on
// out_stall_i. Totals appear on the result of the cell marked last of day and are then
// cleared. Write configuration only while no cell is in flight.
module vegetation_cell_daily_update_top #(
  parameter int CellsPerAxis       = vcdu_pkg::CELLS_PER_AXIS,
  parameter int RecoveryTableDepth = vcdu_pkg::RECOVERY_TABLE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vcdu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vcdu_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [15:0]             region_x_i,
  input  logic signed [15:0]             region_y_i,
  input  logic [7:0]                     local_index_i,
  input  logic signed [15:0]             mean_temperature_i,
  input  logic [16:0]                    soil_saturation_i,
  input  logic signed [17:0]             elevation_i,
  input  logic [16:0]                    forest_potential_i,
  input  logic [16:0]                    disturbance_before_i,
  input  logic [16:0]                    biomass_before_i,
  input  logic                           last_of_day_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     cell_status_o,
  output logic [16:0]                    disturbance_after_o,
  output logic [16:0]                    biomass_after_o,
  output logic [24:0]                    cell_area_o,
  output logic [31:0]                    land_count_total_o,
  output logic [47:0]                    land_area_total_o,
  output logic [47:0]                    biomass_area_before_o,
  output logic [47:0]                    biomass_area_after_o,
  output logic [47:0]                    disturbance_area_before_o,
  output logic [47:0]                    disturbance_area_after_o,
  output logic                           day_done_o,
  output logic                           day_error_o
);

  vcdu_pkg::cmd_t cmd;
  vcdu_pkg::sts_t sts;

  vcdu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vcdu_dpath #(
    .CellsPerAxis       (CellsPerAxis),
    .RecoveryTableDepth (RecoveryTableDepth)
  ) u_dpath (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .cmd_i                     (cmd),
    .sts_o                     (sts),
    .cfg_we_i                  (cfg_we_i),
    .cfg_index_i               (cfg_index_i),
    .cfg_data_i                (cfg_data_i),
    .region_x_i                (region_x_i),
    .region_y_i                (region_y_i),
    .local_index_i             (local_index_i),
    .mean_temperature_i        (mean_temperature_i),
    .soil_saturation_i         (soil_saturation_i),
    .elevation_i               (elevation_i),
    .forest_potential_i        (forest_potential_i),
    .disturbance_before_i      (disturbance_before_i),
    .biomass_before_i          (biomass_before_i),
    .last_of_day_i             (last_of_day_i),
    .out_valid_o               (out_valid_o),
    .out_stall_i               (out_stall_i),
    .cell_status_o             (cell_status_o),
    .disturbance_after_o       (disturbance_after_o),
    .biomass_after_o           (biomass_after_o),
    .cell_area_o               (cell_area_o),
    .land_count_total_o        (land_count_total_o),
    .land_area_total_o         (land_area_total_o),
    .biomass_area_before_o     (biomass_area_before_o),
    .biomass_area_after_o      (biomass_area_after_o),
    .disturbance_area_before_o (disturbance_area_before_o),
    .disturbance_area_after_o  (disturbance_area_after_o),
    .day_done_o                (day_done_o),
    .day_error_o               (day_error_o)
  );

endmodule
